### rtl/cfs_pkg.sv
// Shared types, codes and color math for the color fade slot bank.
`default_nettype none
package cfs_pkg;

  localparam int unsigned SLOTS_DEF   = 8;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [15:0] IDLE_RESET  = 16'd2689;
  localparam logic [15:0] RED565      = 16'hF800;
  localparam logic [16:0] ONE_Q16     = 17'h10000;

  localparam logic [2:0] REQ_TICK    = 3'd0;
  localparam logic [2:0] REQ_FADE    = 3'd1;
  localparam logic [2:0] REQ_RAINBOW = 3'd2;
  localparam logic [2:0] REQ_STOP    = 3'd3;
  localparam logic [2:0] REQ_READ    = 3'd4;

  typedef enum logic [2:0] {
    CMD_TICK, CMD_FADE, CMD_RAINBOW, CMD_STOP, CMD_READ, CMD_NOP
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SCAN, ST_DIV_FADE, ST_DIV_MOD, ST_HUE_DIV, ST_DIV_HUE,
    ST_HUE_COLOR, ST_SQ, ST_CUBE, ST_BLEND, ST_NEXT, ST_RESP
  } state_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [2:0]  slot;
    logic [15:0] color_from;
    logic [15:0] color_to;
    logic [15:0] duration_ms;
    logic        repeat_req;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [2:0]  slot_out;
    logic [15:0] color;
    logic        slot_active;
  } rsp_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  slot;
    logic [15:0] color_from;
    logic [15:0] color_to;
    logic [15:0] dur;
    logic        rep;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } div_in_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quo;
    logic [15:0] rem;
  } div_out_t;

  function automatic logic [15:0] pack565(input logic [7:0] r8, input logic [7:0] g8,
                                          input logic [7:0] b8);
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

  // Integer HSV with S = V = 1; sector = floor(6h/255), capped at 5.
  function automatic logic [15:0] hue_to_rgb565(input logic [7:0] hue);
    logic [10:0] u;
    logic [2:0]  sector;
    logic [7:0]  frac;
    logic [7:0]  x;
    logic [15:0] c;
    u = 11'(hue) * 11'd6;
    if (u >= 11'd1275)      sector = 3'd5;
    else if (u >= 11'd1020) sector = 3'd4;
    else if (u >= 11'd765)  sector = 3'd3;
    else if (u >= 11'd510)  sector = 3'd2;
    else if (u >= 11'd255)  sector = 3'd1;
    else                    sector = 3'd0;
    frac = 8'(u - 11'(sector) * 11'd255);
    x = sector[0] ? (8'd255 - frac) : frac;
    unique case (sector)
      3'd0:    c = pack565(8'd255, x, 8'd0);
      3'd1:    c = pack565(x, 8'd255, 8'd0);
      3'd2:    c = pack565(8'd0, 8'd255, x);
      3'd3:    c = pack565(8'd0, x, 8'd255);
      3'd4:    c = pack565(x, 8'd0, 8'd255);
      default: c = pack565(8'd255, 8'd0, x);
    endcase
    return c;
  endfunction

  // Floored per-channel lerp, s in Q1.16 up to one.
  function automatic logic [15:0] blend565(input logic [15:0] c1, input logic [15:0] c2,
                                           input logic [16:0] s);
    logic [16:0] sn;
    logic [22:0] r;
    logic [22:0] g;
    logic [22:0] b;
    sn = ONE_Q16 - s;
    r = 23'(c1[15:11]) * 23'(sn) + 23'(c2[15:11]) * 23'(s);
    g = 23'(c1[10:5]) * 23'(sn) + 23'(c2[10:5]) * 23'(s);
    b = 23'(c1[4:0]) * 23'(sn) + 23'(c2[4:0]) * 23'(s);
    return {r[20:16], g[21:16], b[20:16]};
  endfunction

endpackage
`default_nettype wire

### rtl/cfs_front.sv
// Request queue: classifies incoming beats and buffers them for the engine.
`default_nettype none
module cfs_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire cfs_pkg::req_t  req_i,
  output logic                item_valid_o,
  input  wire logic           item_pop_i,
  output cfs_pkg::item_t      item_o
);

  cfs_pkg::item_t q_mem [cfs_pkg::QUEUE_DEPTH];
  logic wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cfs_pkg::item_t dec;
  logic do_push, do_pop;

  always_comb begin
    dec.slot       = req_i.slot;
    dec.color_from = req_i.color_from;
    dec.color_to   = req_i.color_to;
    dec.dur        = (req_i.duration_ms == 16'd0) ? 16'd1 : req_i.duration_ms;
    dec.rep        = req_i.repeat_req;
    dec.now        = req_i.now_ms;
    unique case (req_i.req_type)
      cfs_pkg::REQ_TICK:    dec.cmd = cfs_pkg::CMD_TICK;
      cfs_pkg::REQ_FADE:    dec.cmd = cfs_pkg::CMD_FADE;
      cfs_pkg::REQ_RAINBOW: dec.cmd = cfs_pkg::CMD_RAINBOW;
      cfs_pkg::REQ_STOP:    dec.cmd = cfs_pkg::CMD_STOP;
      cfs_pkg::REQ_READ:    dec.cmd = cfs_pkg::CMD_READ;
      default:              dec.cmd = cfs_pkg::CMD_NOP;
    endcase
  end

  assign full         = (cnt_q == 2'(cfs_pkg::QUEUE_DEPTH));
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = q_mem[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= dec;
    end
  end

endmodule
`default_nettype wire

### rtl/cfs_div.sv
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`default_nettype none
module cfs_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cfs_pkg::div_in_t  ctl_i,
  output cfs_pkg::div_out_t      sts_o
);

  logic        busy_q, busy_d, done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] num_q, num_d;
  logic [15:0] rem_q, rem_d, den_q, den_d;
  logic [16:0] trial;
  logic        ge;

  always_comb begin
    trial  = {rem_q, num_q[31]};
    ge     = trial >= {1'b0, den_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (ctl_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = 5'd0;
      num_d  = ctl_i.num;
      rem_d  = 16'd0;
      den_d  = ctl_i.den;
    end else if (busy_q) begin
      rem_d = ge ? 16'(trial - {1'b0, den_q}) : trial[15:0];
      num_d = {num_q[30:0], ge};
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.quo  = num_q;
  assign sts_o.rem  = rem_q;

endmodule
`default_nettype wire

### rtl/cfs_back.sv
// Slot engine: per-slot state, tick sweep, easing and color generation.
`default_nettype none
module cfs_back #(
  parameter int unsigned SLOTS = cfs_pkg::SLOTS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            item_valid_i,
  input  wire cfs_pkg::item_t  item_i,
  output logic                 item_pop_o,
  input  wire logic [15:0]     idle_color_i,
  output logic                 rsp_valid_o,
  output cfs_pkg::rsp_t        rsp_o,
  input  wire logic            rsp_ready_i
);

  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

  cfs_pkg::state_e state_q, state_d;
  cfs_pkg::item_t  item_q, item_d;
  logic [SW-1:0]   idx_q, idx_d, vp_q, vp_d, vp_next, wr_idx, free_idx;
  logic            free_found;
  logic [15:0]     e_q, e_d, t_q, t_d;
  logic [7:0]      hue_q, hue_d;
  logic [31:0]     tt_q, tt_d;
  logic [49:0]     prod_q, prod_d;

  logic            active_q [SLOTS];
  logic            rain_q   [SLOTS];
  logic            loop_q   [SLOTS];
  logic [15:0]     from_q   [SLOTS];
  logic [15:0]     to_q     [SLOTS];
  logic [15:0]     cur_q    [SLOTS];
  logic [31:0]     t0_q     [SLOTS];
  logic [15:0]     dur_q    [SLOTS];

  logic            we_start, we_swap, we_cur, clr_act;
  logic [15:0]     cur_wd;
  logic [31:0]     elapsed;
  logic            past_end;
  logic [17:0]     k;
  logic [17:0]     s_raw;
  logic [16:0]     s;
  logic            in_ok, q_ok, q_act;
  logic [SW-1:0]   in_idx, q_idx;

  cfs_pkg::div_in_t  div_ctl;
  cfs_pkg::div_out_t div_sts;

  cfs_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (div_ctl),
    .sts_o (div_sts)
  );

  // first free slot, lowest index wins
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_q[i]) begin
        free_found = 1'b1;
        free_idx   = SW'(i);
      end
    end
  end

  assign vp_next  = (vp_q == LAST) ? '0 : vp_q + SW'(1);
  assign in_ok    = (32'(item_i.slot) < SLOTS);
  assign in_idx   = SW'(item_i.slot);
  assign q_ok     = (32'(item_q.slot) < SLOTS);
  assign q_idx    = SW'(item_q.slot);
  assign q_act    = q_ok && active_q[q_idx];
  assign elapsed  = item_q.now - t0_q[idx_q];
  assign past_end = elapsed >= {16'd0, dur_q[idx_q]};
  assign k        = 18'd196608 - {1'b0, t_q, 1'b0};
  assign s_raw    = prod_q[49:32];
  assign s        = (s_raw > {1'b0, cfs_pkg::ONE_Q16}) ? cfs_pkg::ONE_Q16 : s_raw[16:0];

  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    idx_d      = idx_q;
    vp_d       = vp_q;
    e_d        = e_q;
    t_d        = t_q;
    hue_d      = hue_q;
    tt_d       = tt_q;
    prod_d     = prod_q;
    item_pop_o = 1'b0;
    we_start   = 1'b0;
    we_swap    = 1'b0;
    we_cur     = 1'b0;
    clr_act    = 1'b0;
    cur_wd     = 16'd0;
    wr_idx     = idx_q;
    div_ctl    = '{start: 1'b0, num: 32'd0, den: dur_q[idx_q]};
    rsp_valid_o = 1'b0;
    rsp_o       = '{slot_out: item_q.slot, color: 16'd0, slot_active: q_act};

    unique case (state_q)
      cfs_pkg::ST_IDLE: begin
        if (item_valid_i) begin
          item_pop_o = 1'b1;
          item_d     = item_i;
          idx_d      = in_idx;
          state_d    = cfs_pkg::ST_RESP;
          unique case (item_i.cmd)
            cfs_pkg::CMD_TICK: begin
              idx_d   = '0;
              state_d = cfs_pkg::ST_SCAN;
            end
            cfs_pkg::CMD_FADE, cfs_pkg::CMD_RAINBOW: begin
              we_start = 1'b1;
              if (free_found) begin
                wr_idx = free_idx;
              end else begin
                wr_idx = vp_next;
                vp_d   = vp_next;
              end
              idx_d = wr_idx;
            end
            cfs_pkg::CMD_STOP: begin
              wr_idx  = in_idx;
              clr_act = in_ok;
            end
            default: ;
          endcase
        end
      end
      cfs_pkg::ST_SCAN: begin
        state_d = cfs_pkg::ST_NEXT;
        if (active_q[idx_q]) begin
          if (rain_q[idx_q]) begin
            if (loop_q[idx_q]) begin
              div_ctl.start = 1'b1;
              div_ctl.num   = elapsed;
              state_d       = cfs_pkg::ST_DIV_MOD;
            end else if (past_end) begin
              clr_act = 1'b1;
            end else begin
              e_d     = elapsed[15:0];
              state_d = cfs_pkg::ST_HUE_DIV;
            end
          end else if (past_end) begin
            if (loop_q[idx_q]) begin
              we_swap = 1'b1;
              t_d     = 16'd0;
              state_d = cfs_pkg::ST_SQ;
            end else begin
              clr_act = 1'b1;
              we_cur  = 1'b1;
              cur_wd  = to_q[idx_q];
            end
          end else begin
            div_ctl.start = 1'b1;
            div_ctl.num   = {elapsed[15:0], 16'd0};
            state_d       = cfs_pkg::ST_DIV_FADE;
          end
        end
      end
      cfs_pkg::ST_DIV_MOD: begin
        if (div_sts.done) begin
          e_d     = div_sts.rem;
          state_d = cfs_pkg::ST_HUE_DIV;
        end
      end
      cfs_pkg::ST_HUE_DIV: begin
        div_ctl.start = 1'b1;
        div_ctl.num   = 32'(e_q) * 32'd255;
        state_d       = cfs_pkg::ST_DIV_HUE;
      end
      cfs_pkg::ST_DIV_HUE: begin
        if (div_sts.done) begin
          hue_d   = div_sts.quo[7:0];
          state_d = cfs_pkg::ST_HUE_COLOR;
        end
      end
      cfs_pkg::ST_HUE_COLOR: begin
        we_cur  = 1'b1;
        cur_wd  = cfs_pkg::hue_to_rgb565(hue_q);
        state_d = cfs_pkg::ST_NEXT;
      end
      cfs_pkg::ST_DIV_FADE: begin
        if (div_sts.done) begin
          t_d     = div_sts.quo[15:0];
          state_d = cfs_pkg::ST_SQ;
        end
      end
      cfs_pkg::ST_SQ: begin
        tt_d    = 32'(t_q) * 32'(t_q);
        state_d = cfs_pkg::ST_CUBE;
      end
      cfs_pkg::ST_CUBE: begin
        prod_d  = 50'(tt_q) * 50'(k);
        state_d = cfs_pkg::ST_BLEND;
      end
      cfs_pkg::ST_BLEND: begin
        we_cur  = 1'b1;
        cur_wd  = cfs_pkg::blend565(from_q[idx_q], to_q[idx_q], s);
        state_d = cfs_pkg::ST_NEXT;
      end
      cfs_pkg::ST_NEXT: begin
        if (idx_q == LAST) begin
          state_d = cfs_pkg::ST_RESP;
        end else begin
          idx_d   = idx_q + SW'(1);
          state_d = cfs_pkg::ST_SCAN;
        end
      end
      cfs_pkg::ST_RESP: begin
        rsp_valid_o = 1'b1;
        unique case (item_q.cmd)
          cfs_pkg::CMD_FADE, cfs_pkg::CMD_RAINBOW: begin
            rsp_o.slot_out    = 3'(idx_q);
            rsp_o.slot_active = 1'b1;
          end
          cfs_pkg::CMD_READ: begin
            rsp_o.color = q_act ? cur_q[idx_q] : idle_color_i;
          end
          default: ;
        endcase
        if (rsp_ready_i) begin
          state_d = cfs_pkg::ST_IDLE;
        end
      end
      default: state_d = cfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfs_pkg::ST_IDLE;
      vp_q    <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        active_q[i] <= 1'b0;
      end
    end else begin
      state_q <= state_d;
      vp_q    <= vp_d;
      if (we_start) begin
        active_q[wr_idx] <= 1'b1;
      end
      if (clr_act) begin
        active_q[wr_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    idx_q  <= idx_d;
    e_q    <= e_d;
    t_q    <= t_d;
    hue_q  <= hue_d;
    tt_q   <= tt_d;
    prod_q <= prod_d;
    if (we_start) begin
      rain_q[wr_idx] <= (item_i.cmd == cfs_pkg::CMD_RAINBOW);
      loop_q[wr_idx] <= item_i.rep;
      t0_q[wr_idx]   <= item_i.now;
      dur_q[wr_idx]  <= item_i.dur;
      if (item_i.cmd == cfs_pkg::CMD_RAINBOW) begin
        cur_q[wr_idx] <= cfs_pkg::RED565;
      end else begin
        cur_q[wr_idx]  <= item_i.color_from;
        from_q[wr_idx] <= item_i.color_from;
        to_q[wr_idx]   <= item_i.color_to;
      end
    end
    if (we_swap) begin
      from_q[wr_idx] <= to_q[wr_idx];
      to_q[wr_idx]   <= from_q[wr_idx];
      t0_q[wr_idx]   <= item_q.now;
    end
    if (we_cur) begin
      cur_q[wr_idx] <= cur_wd;
    end
  end

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");
  a_start_sets_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfs_pkg::ST_RESP && (item_q.cmd == cfs_pkg::CMD_FADE ||
     item_q.cmd == cfs_pkg::CMD_RAINBOW)) |-> active_q[idx_q])
    else $error("started slot not active");
  a_div_wait_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cfs_pkg::ST_DIV_FADE || state_q == cfs_pkg::ST_DIV_MOD ||
     state_q == cfs_pkg::ST_DIV_HUE) |-> (div_sts.busy || div_sts.done))
    else $error("waiting on idle divider");
`endif

endmodule
`default_nettype wire

### rtl/rgb565_color_fade_slots_top.sv
// Top level of the RGB565 color fade slot bank.
// Usage:
//   Requests enter as queue writes: a beat is taken when push is high and
//   full is low. A two-beat request queue decouples the port from the engine.
//   Results leave as queue reads: the result on rsp_o is valid while empty is
//   low and is consumed by pop. Exactly one result beat per request beat.
//   idle_color is written over cfg_valid_i/cfg_ready_o (always ready). The
//   user must write it only while no request is in flight (not enforced).
// Sequencing:
//   A start, stop, read or undefined request passes from the request queue
//   through the engine states ST_IDLE and ST_RESP into the result register.
//   A tick sweeps every slot: a running fade needs one division, a looping
//   rainbow two, a one-shot rainbow inside its period one and a looping fade
//   that wraps none, all on the shared one-bit-per-cycle divider. One request
//   is worked at a time; the engine takes the next only from ST_IDLE.
// Reset:
//   All slots go idle, the victim pointer returns to slot 0, idle_color
//   returns to 2689, both queues empty.
// Backpressure:
//   If pop stays low the result register holds, the engine waits with the
//   next result and the request queue fills until full rises.
`default_nettype none
module rgb565_color_fade_slots_top #(
  parameter int unsigned SLOTS = cfs_pkg::SLOTS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire cfs_pkg::req_t  req_i,
  output logic                empty,
  input  wire logic           pop,
  output cfs_pkg::rsp_t       rsp_o,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [15:0]    cfg_data_i
);

  logic            item_valid, item_pop;
  cfs_pkg::item_t  item;
  logic            eng_valid, eng_ready;
  cfs_pkg::rsp_t   eng_rsp;
  logic [15:0]     idle_q;
  logic            out_valid_q, out_valid_d;
  cfs_pkg::rsp_t   out_q;

  // request queue and decode
  cfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .item_valid_o(item_valid),
    .item_pop_i  (item_pop),
    .item_o      (item)
  );

  // slot engine
  cfs_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .idle_color_i(idle_q),
    .rsp_valid_o (eng_valid),
    .rsp_o       (eng_rsp),
    .rsp_ready_i (eng_ready)
  );

  // config register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idle_q <= cfs_pkg::IDLE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      idle_q <= cfg_data_i;
    end
  end

  // result register: refills in the same cycle it is popped
  assign eng_ready = !out_valid_q || pop;
  assign empty     = !out_valid_q;
  assign rsp_o     = out_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (eng_valid && eng_ready) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_valid && eng_ready) begin
      out_q <= eng_rsp;
    end
  end

endmodule
`default_nettype wire

### verif/tb_rgb565_color_fade_slots_top.sv
// Testbench for the RGB565 color fade slot bank: queued request/result beats checked against a predictor.
`timescale 1ns / 1ps
module tb_rgb565_color_fade_slots_top;

  localparam int NSLOT = 8;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  cfs_pkg::req_t req_i;
  cfs_pkg::rsp_t rsp_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [15:0] cfg_data_i;

  rgb565_color_fade_slots_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .req_i(req_i),
    .empty(empty), .pop(pop), .rsp_o(rsp_o), .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // Shadow copy of the slot bank.
  logic [15:0] idle_shadow;
  logic        act_q [NSLOT];
  logic        rainbow_q [NSLOT];
  logic        loop_q [NSLOT];
  logic [15:0] from_q [NSLOT];
  logic [15:0] to_q [NSLOT];
  logic [15:0] cur_q [NSLOT];
  logic [31:0] t0_q [NSLOT];
  logic [15:0] dur_q [NSLOT];
  logic [2:0]  victim_q;

  cfs_pkg::req_t pending_reqs[$];
  cfs_pkg::rsp_t expected_rsps[$];
  int   mismatches;
  bit   stim_done;
  bit   no_idle;        // last part of the run: no bursts on either side
  bit   hold_send;      // sender hold-off until results drained
  int   send_gap, pop_gap;

  // full_seen: low when the beat on the port was refused at the last rising edge.
  logic full_seen;

  function automatic logic [15:0] rgb(input logic [7:0] r, input logic [7:0] g,
                                      input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] hue_color(input logic [7:0] h);
    int unsigned u, sec, fr, x;
    u = 32'(h) * 6; sec = u / 255; fr = u % 255;
    x = sec[0] ? 255 - fr : fr;
    case (sec)
      0: return rgb(8'd255, 8'(x), 8'd0);
      1: return rgb(8'(x), 8'd255, 8'd0);
      2: return rgb(8'd0, 8'd255, 8'(x));
      3: return rgb(8'd0, 8'(x), 8'd255);
      4: return rgb(8'(x), 8'd0, 8'd255);
      default: return rgb(8'd255, 8'd0, 8'(x));
    endcase
  endfunction

  function automatic logic [31:0] smoothstep(input logic [31:0] t);
    logic [63:0] tt, k, s;
    tt = 64'(t) * 64'(t);
    k = 64'd196608 - 64'(2 * 64'(t));
    s = (tt * k) >> 32;
    return (s > 65536) ? 32'd65536 : s[31:0];
  endfunction

  function automatic logic [15:0] lerp565(input logic [15:0] a, input logic [15:0] b,
                                          input logic [31:0] s);
    logic [63:0] r, g, bl;
    r  = (64'(a[15:11]) * (65536 - s) + 64'(b[15:11]) * s) >> 16;
    g  = (64'(a[10:5]) * (65536 - s) + 64'(b[10:5]) * s) >> 16;
    bl = (64'(a[4:0]) * (65536 - s) + 64'(b[4:0]) * s) >> 16;
    return {r[4:0], g[5:0], bl[4:0]};
  endfunction

  function automatic void advance(input int i, input logic [31:0] now);
    logic [31:0] el, d, e;
    logic [63:0] p;
    logic [15:0] sw;
    el = now - t0_q[i];
    d = (dur_q[i] == 0) ? 32'd1 : 32'(dur_q[i]);
    if (rainbow_q[i]) begin
      if (loop_q[i]) e = el % d;
      else if (el >= d) begin
        act_q[i] = 0;
        return;
      end else e = el;
      cur_q[i] = hue_color(8'((64'(e) * 255) / d));
    end else begin
      p = (64'(el) << 16) / d;
      if (p >= 65536) begin
        if (loop_q[i]) begin
          sw = from_q[i]; from_q[i] = to_q[i]; to_q[i] = sw;
          t0_q[i] = now; p = 0;
        end else begin
          act_q[i] = 0;
          cur_q[i] = to_q[i];
          return;
        end
      end
      cur_q[i] = lerp565(from_q[i], to_q[i], smoothstep(p[31:0]));
    end
  endfunction

  // Runs one accepted request beat through the shadow bank.
  function automatic cfs_pkg::rsp_t predict_slot_bank(input cfs_pkg::req_t r);
    cfs_pkg::rsp_t o;
    int i;
    logic [2:0] s;
    logic [15:0] d;
    s = r.slot;
    d = (r.duration_ms == 0) ? 16'd1 : r.duration_ms;
    o.color = 0;
    case (r.req_type)
      cfs_pkg::REQ_TICK: for (i = 0; i < NSLOT; i++) if (act_q[i]) advance(i, r.now_ms);
      cfs_pkg::REQ_FADE, cfs_pkg::REQ_RAINBOW: begin
        i = -1;
        for (int k = NSLOT - 1; k >= 0; k--) if (!act_q[k]) i = k;
        if (i < 0) begin
          victim_q = victim_q + 3'd1;
          i = int'(victim_q);
        end
        act_q[i] = 1; t0_q[i] = r.now_ms; dur_q[i] = d; loop_q[i] = r.repeat_req;
        rainbow_q[i] = (r.req_type == cfs_pkg::REQ_RAINBOW);
        if (r.req_type == cfs_pkg::REQ_FADE) begin
          from_q[i] = r.color_from; to_q[i] = r.color_to; cur_q[i] = r.color_from;
        end else cur_q[i] = hue_color(8'd0);
        s = 3'(i);
      end
      cfs_pkg::REQ_STOP: act_q[s] = 0;
      cfs_pkg::REQ_READ: o.color = act_q[s] ? cur_q[s] : idle_shadow;
      default: ;
    endcase
    o.slot_out = s;
    o.slot_active = act_q[s];
    return o;
  endfunction

  // Clock and timeout.
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #40ms;
    $display("tb_rgb565_color_fade_slots_top NOT OK");
    $finish;
  end

  // Driver: presents the head of pending_reqs and drives pop, with random idle bursts.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (push && !full_seen) begin
        // previous beat not yet taken: hold
      end else begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          push <= 0;
        end else if (pending_reqs.size() > 0 && !hold_send) begin
          req_i <= pending_reqs.pop_front();
          push <= 1;
          if (!no_idle && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 8);
        end else push <= 0;
      end
      if (pop_gap > 0) begin
        pop_gap <= pop_gap - 1;
        pop <= 0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        pop_gap <= $urandom_range(0, 7);
        pop <= 0;
      end else pop <= 1;
    end
  end

  // Monitor: predicts on accepted requests, checks accepted results.
  always @(posedge clk_i) begin
    cfs_pkg::rsp_t want;
    full_seen <= !(rst_ni && push && full);
    if (rst_ni) begin
      if (push && !full) begin
        expected_rsps.push_back(predict_slot_bank(req_i));
      end
      if (pop && !empty) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat %p", rsp_o);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_o !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected slot %0d color %h active %b, got %0d %h %b",
                       want.slot_out, want.color, want.slot_active,
                       rsp_o.slot_out, rsp_o.color, rsp_o.slot_active);
          end
        end
      end
    end
  end

  function automatic cfs_pkg::req_t mk(input logic [2:0] op, input logic [2:0] s,
                              input logic [15:0] c1, input logic [15:0] c2,
                              input logic [15:0] d, input logic rep, input logic [31:0] t);
    cfs_pkg::req_t r;
    r.req_type = op; r.slot = s; r.color_from = c1; r.color_to = c2;
    r.duration_ms = d; r.repeat_req = rep; r.now_ms = t;
    return r;
  endfunction

  task automatic drain();
    while (pending_reqs.size() > 0 || push || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (1200) @(posedge clk_i);   // a full tick over eight looping rainbows
  endtask

  task automatic write_idle(input logic [15:0] v);
    @(negedge clk_i);
    cfg_data_i <= v; cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    idle_shadow = v;
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  // Random fade duration: zero, 16'hFFFF or 1 to 300, so fades land mid-way and at the end.
  function automatic logic [15:0] rnd_dur();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(1, 300));
    endcase
  endfunction

  logic [31:0] now;

  task automatic random_phase(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: begin
          now = now + $urandom_range(0, 120);
          if ($urandom_range(0, 40) == 0) now = $urandom;
          pending_reqs.push_back(mk(cfs_pkg::REQ_TICK, 3'($urandom), 16'($urandom),
                                    16'($urandom), 16'($urandom), 1'($urandom), now));
        end
        7, 8, 9: pending_reqs.push_back(mk(cfs_pkg::REQ_FADE, 3'($urandom), 16'($urandom),
                                           16'($urandom), rnd_dur(), 1'($urandom), now));
        10, 11: pending_reqs.push_back(mk(cfs_pkg::REQ_RAINBOW, 3'($urandom),
                                          16'($urandom), 16'($urandom), rnd_dur(),
                                          1'($urandom), now));
        12: pending_reqs.push_back(mk(cfs_pkg::REQ_STOP, 3'($urandom), 16'($urandom),
                                      16'($urandom), 16'($urandom), 1'($urandom),
                                      $urandom));
        13: pending_reqs.push_back(mk(3'($urandom_range(5, 7)), 3'($urandom),
                                      16'($urandom), 16'($urandom), 16'($urandom),
                                      1'($urandom), $urandom));
        default: pending_reqs.push_back(mk(cfs_pkg::REQ_READ, 3'($urandom),
                                           16'($urandom), 16'($urandom), 16'($urandom),
                                           1'($urandom), $urandom));
      endcase
    end
  endtask

  initial begin
    rst_ni = 0; push = 0; pop = 0; req_i = '0;
    cfg_valid_i = 0; cfg_data_i = '0;
    mismatches = 0; stim_done = 0; no_idle = 0; hold_send = 0;
    send_gap = 0; pop_gap = 0; full_seen = 1;
    idle_shadow = cfs_pkg::IDLE_RESET; victim_q = 0;
    for (int i = 0; i < NSLOT; i++) begin
      act_q[i] = 0; rainbow_q[i] = 0; loop_q[i] = 0; from_q[i] = 0; to_q[i] = 0;
      cur_q[i] = 0; t0_q[i] = 0; dur_q[i] = 0;
    end
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1;

    // Directed: reset idle color, zero duration, one-shot and looping ends,
    // all slots busy (victim overwrite), stop, undefined ops, time wrap.
    now = 32'hFFFF_FFF0;
    pending_reqs.push_back(mk(cfs_pkg::REQ_READ, 3'd7, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(cfs_pkg::REQ_FADE, 0, 16'hFFFF, 16'h0000, 16'd0, 1'b0, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_FADE, 0, 16'h0000, 16'hFFFF, 16'd20, 1'b1, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_RAINBOW, 0, 0, 0, 16'd0, 1'b0, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_RAINBOW, 0, 0, 0, 16'd255, 1'b1, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_FADE, 0, 16'hF800, 16'h07E0, 16'hFFFF, 1'b0,
                              now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_RAINBOW, 0, 0, 0, 16'd40, 1'b0, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_FADE, 0, 16'h001F, 16'hF81F, 16'd10, 1'b1, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_FADE, 0, 16'h1234, 16'hABCD, 16'd7, 1'b0, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_RAINBOW, 0, 0, 0, 16'd5, 1'b1, now));
    pending_reqs.push_back(mk(cfs_pkg::REQ_TICK, 0, 0, 0, 0, 0, now + 32'd10));
    pending_reqs.push_back(mk(cfs_pkg::REQ_TICK, 0, 0, 0, 0, 0, now + 32'd30));
    for (int s = 0; s < 8; s++)
      pending_reqs.push_back(mk(cfs_pkg::REQ_READ, 3'(s), 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(cfs_pkg::REQ_STOP, 3'd2, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(3'd5, 3'd1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(3'd7, 3'd2, 0, 0, 0, 0, 0));
    now = now + 30;
    drain();

    write_idle(16'h0000);
    random_phase(500);
    // hold-off mid-phase: let every expected result come back
    while (pending_reqs.size() > 250) @(posedge clk_i);
    hold_send = 1;
    while (push || expected_rsps.size() > 0) @(posedge clk_i);
    hold_send = 0;
    drain();
    write_idle(16'hFFFF);
    random_phase(700);
    drain();
    write_idle(16'($urandom));
    no_idle = 1;
    random_phase(800);
    drain();
    stim_done = 1;

    if (mismatches == 0 && expected_rsps.size() == 0)
      $display("tb_rgb565_color_fade_slots_top OK");
    else
      $display("tb_rgb565_color_fade_slots_top NOT OK");
    $finish;
  end

endmodule
